// ===== rtl/escc_pkg.sv =====
// Shared types, constants and the month table for the epoch seconds calendar converter.
package escc_pkg;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic {
    STATUS_OK        = 1'b0,
    STATUS_BAD_MONTH = 1'b1
  } status_t;

  localparam int TDATA_W = 72;

  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_MAR   = 4'd3;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [4:0]  LEAP_DAY    = 5'd29;
  localparam logic [11:0] EPOCH_YEAR  = 12'd1970;

  // 365 * 1970 + 492 + 1: removes the epoch year, the leap days through 1968
  // and the one-based day of month in a single constant.
  localparam logic [31:0] ENC_DAY_BIAS = 32'd719543;

  // Offset that lines day numbers up with the four-year leap cycle.
  localparam logic [15:0] QUAD_BIAS = 16'd671;

  // Reciprocals for exact division by constants: q = (x * M) >> S.
  localparam logic [30:0] RECIP15_S34   = 31'd1145324613; // x < 2^30
  localparam logic [25:0] RECIP15_S29   = 26'd35791395;   // x < 2^25
  localparam logic [18:0] RECIP3_S20    = 19'd349526;     // x < 2^18
  localparam logic [16:0] RECIP1461_S27 = 17'd91868;      // x < 2^16
  localparam logic [16:0] RECIP365_S25  = 17'd91930;      // x < 2^16

  // Days before the first of each month in a common year (index 0 is January).
  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [5:0]  t_lo;
    logic [26:0] q1;
    logic [31:0] acc;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } s1_t;

  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [5:0]  sec;
    logic [5:0]  q1_lo;
    logic [20:0] q2;
    logic [31:0] acc;
    logic [5:0]  minute;
    logic [5:0]  second;
  } s2_t;

  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  q2_lo;
    logic [15:0] days;
    logic [31:0] acc;
    logic [5:0]  second;
  } s3_t;

  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [15:0] days;
    logic [10:0] x_lo;
    logic [5:0]  quads;
    logic [31:0] acc;
  } s4_t;

  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [15:0] rem;
    logic        qrem_nz;
    logic [31:0] acc;
  } s5_t;

  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [8:0]  rem_lo;
    logic [7:0]  yq;
    logic        qrem_nz;
    logic [31:0] acc;
  } s6_t;

  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [8:0]  ryear;
    logic [11:0] year;
    logic        qrem_nz;
    logic [31:0] acc;
  } s7_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } res_t;

endpackage

// ===== rtl/epoch_seconds_calendar_convert.sv =====
// Pipelined converter between epoch seconds and calendar date and time of day.
//
// The block converts in both directions between seconds since 1970-01-01
// 00:00:00 and year, month, day, hour, minute and second, counting every
// fourth year as a leap year, so dates are right from 1970 through 2099.
// The input item arrives on the in_ stream: in_tuser selects the direction
// (0 encodes calendar fields to seconds, 1 decodes seconds to calendar
// fields) and in_tdata carries all fields of both directions. Each item
// gives exactly one result item on the out_ stream; out_tuser is the status
// flag, set when an encode sees a month outside 1 to 12. Fields that do not
// apply to the chosen direction come out as zero.
// The datapath is eight register stages, the last one being the output
// register; the reciprocal multipliers that divide by 60, 60, 24, 1461 and
// 365 are each followed by a register. One item is taken every cycle unless
// the output stalls. When out_tready is low with a result waiting,
// every stage holds and in_tready drops, so nothing is lost or repeated.
// A synchronous reset clears all stage valid bits; the block keeps no other
// state between items.
module epoch_seconds_calendar_convert (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // Lowest bit up: seconds_in[31:0], year_in[43:32], month_in[47:44],
  // day_in[52:48], hour_in[57:53], minute_in[63:58], second_in[69:64], zeros.
  input  logic [escc_pkg::TDATA_W-1:0] in_tdata,
  // op: 0 encodes, 1 decodes.
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // Lowest bit up: seconds_out[31:0], year_out[43:32], month_out[47:44],
  // day_out[52:48], hour_out[57:53], minute_out[63:58], second_out[69:64], zeros.
  output logic [escc_pkg::TDATA_W-1:0] out_tdata,
  // status: 0 ok, 1 month out of range on encode.
  output logic                        out_tuser
);

  import escc_pkg::*;

  // One valid bit per stage; bit 7 belongs to the output register.
  logic [7:0] vld_r;
  logic [7:0] vld_nxt;
  logic       adv;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  s5_t  s5_r, s5_nxt;
  s6_t  s6_r, s6_nxt;
  s7_t  s7_r, s7_nxt;
  res_t res_r, res_nxt;

  // Encode input fields.
  logic [11:0] enc_year;
  logic [3:0]  enc_month;
  logic        enc_leap_adj;

  // Reciprocal products.
  logic [60:0] prod1;
  logic [50:0] prod2;
  logic [36:0] prod3;
  logic [15:0] quad_x;
  logic [32:0] prod4;
  logic [10:0] quad_rem;
  logic [32:0] prod6;

  // Month search.
  logic [3:0] dec_month;
  logic [8:0] dec_day9;
  logic [4:0] dec_day;

  // All stages move together; the pipe stalls only when the output register
  // holds a result that the receiver does not take.
  assign adv       = !vld_r[7] || out_tready;
  assign in_tready = adv;
  assign vld_nxt   = {vld_r[6:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: divide seconds by 60 and form the encode day count.
  assign enc_year     = in_tdata[43:32];
  assign enc_month    = in_tdata[47:44];
  assign enc_leap_adj = (enc_month <= MONTH_FEB) && (enc_year[1:0] == 2'b00);
  assign prod1        = 61'(in_tdata[31:2]) * 61'(RECIP15_S34);

  always_comb begin
    s1_nxt.op     = op_t'(in_tuser);
    s1_nxt.bad    = !(enc_month inside {[MONTH_FIRST:MONTH_LAST]});
    s1_nxt.t_lo   = in_tdata[5:0];
    s1_nxt.q1     = prod1[60:34];
    s1_nxt.acc    = 32'(enc_year) * 32'd365 + 32'(enc_year[11:2])
                  + 32'(cum_days(4'(enc_month - 4'd1))) + 32'(in_tdata[52:48])
                  - ENC_DAY_BIAS - 32'(enc_leap_adj);
    s1_nxt.hour   = in_tdata[57:53];
    s1_nxt.minute = in_tdata[63:58];
    s1_nxt.second = in_tdata[69:64];
  end

  // Stage 2: seconds remainder, minutes divided by 60, days to hours.
  assign prod2 = 51'(s1_r.q1[26:2]) * 51'(RECIP15_S29);

  always_comb begin
    s2_nxt.op     = s1_r.op;
    s2_nxt.bad    = s1_r.bad;
    s2_nxt.sec    = 6'(s1_r.t_lo - 6'(s1_r.q1[5:0] * 6'd60));
    s2_nxt.q1_lo  = s1_r.q1[5:0];
    s2_nxt.q2     = prod2[49:29];
    s2_nxt.acc    = s1_r.acc * 32'd24 + 32'(s1_r.hour);
    s2_nxt.minute = s1_r.minute;
    s2_nxt.second = s1_r.second;
  end

  // Stage 3: minutes remainder, hours divided by 24, hours to minutes.
  assign prod3 = 37'(s2_r.q2[20:3]) * 37'(RECIP3_S20);

  always_comb begin
    s3_nxt.op     = s2_r.op;
    s3_nxt.bad    = s2_r.bad;
    s3_nxt.sec    = s2_r.sec;
    s3_nxt.min    = 6'(s2_r.q1_lo - 6'(s2_r.q2[5:0] * 6'd60));
    s3_nxt.q2_lo  = s2_r.q2[4:0];
    s3_nxt.days   = prod3[35:20];
    s3_nxt.acc    = s2_r.acc * 32'd60 + 32'(s2_r.minute);
    s3_nxt.second = s2_r.second;
  end

  // Stage 4: hours remainder, four-year cycles, minutes to seconds.
  assign quad_x = s3_r.days + QUAD_BIAS;
  assign prod4  = 33'(quad_x) * 33'(RECIP1461_S27);

  always_comb begin
    s4_nxt.op    = s3_r.op;
    s4_nxt.bad   = s3_r.bad;
    s4_nxt.sec   = s3_r.sec;
    s4_nxt.min   = s3_r.min;
    s4_nxt.hr    = 5'(s3_r.q2_lo - 5'(s3_r.days[4:0] * 5'd24));
    s4_nxt.days  = s3_r.days;
    s4_nxt.x_lo  = quad_x[10:0];
    s4_nxt.quads = prod4[32:27];
    s4_nxt.acc   = s3_r.acc * 32'd60 + 32'(s3_r.second);
  end

  // Stage 5: drop one day per four-year cycle and note where in that cycle the day is.
  assign quad_rem = 11'(s4_r.x_lo - 11'({5'b0, s4_r.quads} * 11'd1461));

  always_comb begin
    s5_nxt.op      = s4_r.op;
    s5_nxt.bad     = s4_r.bad;
    s5_nxt.sec     = s4_r.sec;
    s5_nxt.min     = s4_r.min;
    s5_nxt.hr      = s4_r.hr;
    s5_nxt.rem     = s4_r.days - 16'(s4_r.quads);
    s5_nxt.qrem_nz = (quad_rem != 11'd0);
    s5_nxt.acc     = s4_r.acc;
  end

  // Stage 6: whole 365-day years.
  assign prod6 = 33'(s5_r.rem) * 33'(RECIP365_S25);

  always_comb begin
    s6_nxt.op      = s5_r.op;
    s6_nxt.bad     = s5_r.bad;
    s6_nxt.sec     = s5_r.sec;
    s6_nxt.min     = s5_r.min;
    s6_nxt.hr      = s5_r.hr;
    s6_nxt.rem_lo  = s5_r.rem[8:0];
    s6_nxt.yq      = prod6[32:25];
    s6_nxt.qrem_nz = s5_r.qrem_nz;
    s6_nxt.acc     = s5_r.acc;
  end

  // Stage 7: day of year and calendar year.
  always_comb begin
    s7_nxt.op      = s6_r.op;
    s7_nxt.bad     = s6_r.bad;
    s7_nxt.sec     = s6_r.sec;
    s7_nxt.min     = s6_r.min;
    s7_nxt.hr      = s6_r.hr;
    s7_nxt.ryear   = 9'(s6_r.rem_lo - 9'({1'b0, s6_r.yq} * 9'd365));
    s7_nxt.year    = EPOCH_YEAR + 12'(s6_r.yq);
    s7_nxt.qrem_nz = s6_r.qrem_nz;
    s7_nxt.acc     = s6_r.acc;
  end

  // Stage 8: month lookup against the table, leap-day patch, result select.
  // The table rises, so the last month whose start is not past the day wins.
  always_comb begin
    dec_month = MONTH_FIRST;
    for (int k = 1; k < 12; k++) begin
      if (s7_r.ryear >= cum_days(4'(k))) begin
        dec_month = 4'(k + 1);
      end
    end
  end

  assign dec_day9 = 9'(s7_r.ryear - cum_days(4'(dec_month - 4'd1)) + 9'd1);
  assign dec_day  = dec_day9[4:0];

  always_comb begin
    res_nxt = '0;
    if (s7_r.op == OP_ENCODE) begin
      res_nxt.status  = s7_r.bad ? STATUS_BAD_MONTH : STATUS_OK;
      res_nxt.seconds = s7_r.bad ? 32'd0 : s7_r.acc;
    end else begin
      res_nxt.status = STATUS_OK;
      res_nxt.year   = s7_r.year;
      res_nxt.month  = dec_month;
      res_nxt.day    = dec_day;
      // March 1 of a leap year is really February 29, except on the first
      // day of a four-year cycle where the table arithmetic is already right.
      if (dec_month == MONTH_MAR && dec_day == 5'd1 && s7_r.year[1:0] == 2'b00 &&
          s7_r.qrem_nz) begin
        res_nxt.month = MONTH_FEB;
        res_nxt.day   = LEAP_DAY;
      end
      res_nxt.hour   = s7_r.hr;
      res_nxt.minute = s7_r.min;
      res_nxt.second = s7_r.sec;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      s5_r  <= s5_nxt;
      s6_r  <= s6_nxt;
      s7_r  <= s7_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = vld_r[7];
  assign out_tuser  = res_r.status;
  assign out_tdata  = {2'b00, res_r.second, res_r.minute, res_r.hour, res_r.day,
                       res_r.month, res_r.year, res_r.seconds};

`ifndef SYNTHESIS
  // An accepted item always occupies the first stage on the next edge.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item did not enter the first stage");

  // Exact division: minute and second remainders stay below 60.
  a_min_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && s3_r.op == OP_DECODE |-> s3_r.sec < 6'd60 && s3_r.min < 6'd60)
    else $error("decoded minute or second out of range");

  // The day of year left after removing whole years is below 365.
  a_day_of_year: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] && s7_r.op == OP_DECODE |-> s7_r.ryear < 9'd365)
    else $error("day of year out of range");

  // A rejected month never carries a seconds value.
  a_bad_month_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_BAD_MONTH |-> out_tdata[31:0] == 32'd0)
    else $error("bad month result carries seconds");
`endif

endmodule
